// ===== hdl/lut_linear_interp_16bit_modes_top_macros.svh =====
// Assertion macros for the interpolation lookup block
`ifndef LUT_LINEAR_INTERP_16BIT_MODES_TOP_MACROS_SVH
`define LUT_LINEAR_INTERP_16BIT_MODES_TOP_MACROS_SVH

// same-cycle implication
`define LLI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lli: same-cycle check failed");

// next-cycle implication
`define LLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lli: next-cycle check failed");

`endif

// ===== hdl/lli_pkg.sv =====
// Shared types, constants and command/status bundles for the interpolation lookup
package lli_pkg;

   localparam int MAX_POINTS_DEF = 16;

   localparam int DATA_W  = 16;
   localparam int COUNT_W = 5;
   localparam int INDEX_W = 4;
   localparam int MODE_W  = 2;

   // request tdata layout, lowest bit first
   localparam int IDX_LSB     = 0;
   localparam int PX_LSB      = IDX_LSB + INDEX_W;
   localparam int PY_LSB      = PX_LSB + DATA_W;
   localparam int QX_LSB      = PY_LSB + DATA_W;
   localparam int MODE_LSB    = QX_LSB + DATA_W;
   localparam int REQ_USED_W  = MODE_LSB + MODE_W;
   localparam int REQ_TDATA_W = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = DATA_W;

   // arithmetic widths
   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int RES_W  = PROD_W + 1;
   localparam int DIV_NUM_W = 2 * DATA_W;
   localparam int DIV_DEN_W = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam logic signed [DATA_W-1:0] INT16_MAX = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] INT16_MIN = 16'sh8000;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [MODE_W-1:0] MODE_EXTRAP   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POSITIVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LIMIT    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CALIB    = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] x;
   } lli_point_type;

   typedef enum logic {
      RD_LAST,
      RD_PTR
   } lli_rd_sel_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_ABOVE,
      PTR_INC
   } lli_ptr_op_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_Y0,
      RES_CAL,
      RES_Y2,
      RES_INTERP
   } lli_res_sel_type;

   typedef struct packed {
      logic            accept;
      logic            mem_wr;
      lli_rd_sel_type  rd_sel;
      lli_ptr_op_type  ptr_op;
      logic            lat_last;
      logic            lat_first;
      logic            lat_prev;
      logic            lat_cur;
      logic            seg_go;
      logic            mul_go;
      logic            div_go;
      logic            res_load;
      lli_res_sel_type res_sel;
      logic            out_load;
   } lli_cmd_type;

   typedef struct packed {
      logic in_write;
      logic n_lt2;
      logic above;
      logic hit;
      logic limit_below;
      logic cal_above;
      logic den_zero;
      logic div_done;
   } lli_status_type;

endpackage

// ===== hdl/lli_div.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle
module lli_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lli_pkg::DIV_NUM_W-1:0]  dividend,
   input  logic [lli_pkg::DIV_DEN_W-1:0]  divisor,
   output logic [lli_pkg::DIV_NUM_W-1:0]  quotient,
   output logic                           done
);
   import lli_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_DEN_W:0]     rem_ff, rem_in;
   logic [DIV_NUM_W-1:0]   quo_ff, quo_in;
   logic [DIV_DEN_W-1:0]   den_ff, den_in;
   logic [DIV_DEN_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== hdl/lli_datapath.sv =====
// Point memory, segment registers, slope multiply, divide and result saturation
module lli_datapath #(
   parameter int MAX_POINTS = lli_pkg::MAX_POINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [lli_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             csr_we,
   input  logic [lli_pkg::COUNT_W-1:0]      csr_data,
   input  lli_pkg::lli_cmd_type             cmd,
   output lli_pkg::lli_status_type          status,
   output logic [lli_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import lli_pkg::*;

   localparam int ADDR_W  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int LIM_W   = $clog2(MAX_POINTS + 1);
   localparam int CMP_W   = (LIM_W > COUNT_W) ? LIM_W : COUNT_W;

   // request fields
   logic [INDEX_W-1:0]       in_index;
   logic signed [DATA_W-1:0] in_px;
   logic signed [DATA_W-1:0] in_py;
   logic signed [DATA_W-1:0] in_qx;
   logic [MODE_W-1:0]        in_mode;

   assign in_index = req_tdata[IDX_LSB +: INDEX_W];
   assign in_px    = req_tdata[PX_LSB +: DATA_W];
   assign in_py    = req_tdata[PY_LSB +: DATA_W];
   assign in_qx    = req_tdata[QX_LSB +: DATA_W];
   assign in_mode  = req_tdata[MODE_LSB +: MODE_W];

   // control registers
   logic [COUNT_W-1:0] point_count_ff;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic               above_ff;

   // payload registers
   logic signed [DATA_W-1:0] q_ff;
   logic [MODE_W-1:0]        mode_ff;
   lli_point_type            rd_ff;
   lli_point_type            cur_ff, prev_ff;
   logic signed [DATA_W-1:0] x0_ff, y0_ff;
   logic signed [DIFF_W-1:0] dx_ff, dx_in;
   logic signed [DIFF_W-1:0] dy_ff, dy_in;
   logic signed [DIFF_W-1:0] den_ff, den_in;
   logic signed [DATA_W-1:0] y2_ff, y2_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff;
   logic [DATA_W-1:0]        res_ff, res_in;
   logic [RSP_TDATA_W-1:0]   out_ff;

   lli_point_type point_mem [MAX_POINTS];

   // point count limited to the table depth
   logic [CMP_W-1:0]  count_ext;
   logic [CMP_W-1:0]  n_pts;
   logic [ADDR_W-1:0] last_addr;
   logic [ADDR_W-1:0] above_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              idx_ok;
   logic              mem_we;
   lli_point_type     wr_point;

   assign count_ext  = CMP_W'(point_count_ff);
   assign n_pts      = (count_ext > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS) : count_ext;
   assign last_addr  = ADDR_W'(n_pts - CMP_W'(1));
   assign above_addr = ADDR_W'(n_pts - CMP_W'(2));
   assign rd_addr    = (cmd.rd_sel == RD_LAST) ? last_addr : ptr_ff;
   assign wr_addr    = ADDR_W'(in_index);
   assign idx_ok     = CMP_W'(in_index) < CMP_W'(MAX_POINTS);
   assign mem_we     = cmd.mem_wr && idx_ok;
   assign wr_point.x = in_px;
   assign wr_point.y = in_py;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_mem[wr_addr] <= wr_point;
      end
      rd_ff <= point_mem[rd_addr];
   end

   // divider
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] div_quo;
   logic                 div_done;
   logic signed [PROD_W-1:0] prod_neg;
   logic signed [DIFF_W-1:0] den_neg;

   assign prod_neg = -prod_ff;
   assign den_neg  = -den_ff;
   assign div_num  = prod_ff[PROD_W-1] ? DIV_NUM_W'(prod_neg) : DIV_NUM_W'(prod_ff);
   assign div_den  = den_ff[DIFF_W-1] ? DIV_DEN_W'(den_neg) : DIV_DEN_W'(den_ff);

   lli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo),
      .done     (div_done)
   );

   // ptr
   always_comb begin
      case (cmd.ptr_op)
         PTR_HOLD:  ptr_in = ptr_ff;
         PTR_ZERO:  ptr_in = '0;
         PTR_ABOVE: ptr_in = above_addr;
         PTR_INC:   ptr_in = ptr_ff + ADDR_W'(1);
         default:   ptr_in = ptr_ff;
      endcase
   end

   // segment setup
   logic                     below_first;
   logic signed [DATA_W-1:0] xr;

   assign below_first = !above_ff && (q_ff < x0_ff);

   always_comb begin
      xr     = below_first ? x0_ff : cur_ff.x;
      y2_in  = below_first ? y0_ff : cur_ff.y;
      dx_in  = DIFF_W'(xr) - DIFF_W'(q_ff);
      dy_in  = DIFF_W'(cur_ff.y) - DIFF_W'(prev_ff.y);
      den_in = DIFF_W'(cur_ff.x) - DIFF_W'(prev_ff.x);
      prod_in = PROD_W'(dx_ff) * PROD_W'(dy_ff);
   end

   // result select and saturation
   logic signed [RES_W-1:0] quo_s;
   logic signed [RES_W-1:0] wide;
   logic [DATA_W-1:0]       sat;
   logic                    clamp_neg;

   assign quo_s = neg_ff ? -$signed({3'b000, div_quo}) : $signed({3'b000, div_quo});
   assign clamp_neg = (mode_ff == MODE_POSITIVE) || (mode_ff == MODE_CALIB);

   always_comb begin
      case (cmd.res_sel)
         RES_ZERO:   wide = '0;
         RES_Y0:     wide = RES_W'(y0_ff);
         RES_CAL:    wide = RES_W'(q_ff) - (RES_W'(prev_ff.x) - RES_W'(prev_ff.y));
         RES_Y2:     wide = RES_W'(y2_ff);
         RES_INTERP: wide = RES_W'(y2_ff) - quo_s;
         default:    wide = '0;
      endcase
      if (wide > RES_W'(INT16_MAX)) begin
         sat = INT16_MAX;
      end else if (wide < RES_W'(INT16_MIN)) begin
         sat = INT16_MIN;
      end else begin
         sat = wide[DATA_W-1:0];
      end
      res_in = (clamp_neg && sat[DATA_W-1]) ? '0 : sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         ptr_ff         <= '0;
         above_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            point_count_ff <= csr_data;
         end
         ptr_ff <= ptr_in;
         if (cmd.lat_last) begin
            above_ff <= status.above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         q_ff    <= in_qx;
         mode_ff <= in_mode;
      end
      if (cmd.lat_last || cmd.lat_cur) begin
         cur_ff <= rd_ff;
      end
      if (cmd.lat_first) begin
         x0_ff   <= rd_ff.x;
         y0_ff   <= rd_ff.y;
      end
      if (cmd.lat_first || cmd.lat_prev) begin
         prev_ff <= rd_ff;
      end
      if (cmd.seg_go) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         den_ff <= den_in;
         y2_ff  <= y2_in;
      end
      if (cmd.mul_go) begin
         prod_ff <= prod_in;
      end
      if (cmd.div_go) begin
         neg_ff <= prod_ff[PROD_W-1] ^ den_ff[DIFF_W-1];
      end
      if (cmd.res_load) begin
         res_ff <= res_in;
      end
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   always_comb begin
      status.in_write    = (req_tuser == CMD_WRITE);
      status.n_lt2       = n_pts < CMP_W'(2);
      status.above       = q_ff > rd_ff.x;
      status.hit         = q_ff <= rd_ff.x;
      status.limit_below = (mode_ff == MODE_LIMIT) && (q_ff < rd_ff.x);
      status.cal_above   = above_ff && (mode_ff == MODE_CALIB);
      status.den_zero    = den_ff == '0;
      status.div_done    = div_done;
   end

   assign rsp_tdata = out_ff;

endmodule

// ===== hdl/lli_ctrl.sv =====
// Sequencer for table search, divide and result hand-off
module lli_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  lli_pkg::lli_status_type  status,
   output lli_pkg::lli_cmd_type     cmd
);
   import lli_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_CHK_LAST,
      ST_RD_PREV,
      ST_CHK_PREV,
      ST_RD_FIRST,
      ST_CHK_FIRST,
      ST_LIMIT,
      ST_RD_SCAN,
      ST_CHK_SCAN,
      ST_SEG,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (status.in_write) begin
                  cmd.mem_wr = 1'b1;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.rd_sel = RD_LAST;
            if (status.n_lt2) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_ZERO;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_CHK_LAST;
            end
         end
         ST_CHK_LAST: begin
            cmd.lat_last = 1'b1;
            if (status.above) begin
               cmd.ptr_op = PTR_ABOVE;
               state_in   = ST_RD_PREV;
            end else begin
               cmd.ptr_op = PTR_ZERO;
               state_in   = ST_RD_FIRST;
            end
         end
         ST_RD_PREV: begin
            cmd.rd_sel = RD_PTR;
            state_in   = ST_CHK_PREV;
         end
         ST_CHK_PREV: begin
            cmd.lat_prev = 1'b1;
            state_in     = ST_SEG;
         end
         ST_RD_FIRST: begin
            cmd.rd_sel = RD_PTR;
            state_in   = ST_CHK_FIRST;
         end
         ST_CHK_FIRST: begin
            cmd.lat_first = 1'b1;
            cmd.ptr_op    = PTR_INC;
            state_in      = status.limit_below ? ST_LIMIT : ST_RD_SCAN;
         end
         ST_LIMIT: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_Y0;
            state_in     = ST_DONE;
         end
         ST_RD_SCAN: begin
            cmd.rd_sel = RD_PTR;
            state_in   = ST_CHK_SCAN;
         end
         ST_CHK_SCAN: begin
            if (status.hit) begin
               cmd.lat_cur = 1'b1;
               state_in    = ST_SEG;
            end else begin
               cmd.lat_prev = 1'b1;
               cmd.ptr_op   = PTR_INC;
               state_in     = ST_RD_SCAN;
            end
         end
         ST_SEG: begin
            cmd.seg_go = 1'b1;
            if (status.cal_above) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_CAL;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = ST_DIV_START;
         end
         ST_DIV_START: begin
            if (status.den_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_Y2;
               state_in     = ST_DONE;
            end else begin
               cmd.div_go = 1'b1;
               state_in   = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_INTERP;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.out_load  = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

// ===== hdl/lut_linear_interp_16bit_modes_top.sv =====
// Top level of the 16-bit piecewise linear interpolation lookup table
// A write beat stores one (x, y) support point and returns nothing. A lookup beat walks the
// point memory through its single read port, reading and then checking each point visited,
// then forms the slope product and runs a 32-step radix-2 divider, one quotient bit per cycle.
// A calibration lookup above the last point, a limit-mode lookup below the first point and a
// lookup with fewer than two points skip the divider. A new beat is taken once the previous
// lookup has moved its result into the output register, even while that result still waits
// on rsp_tready.
`include "lut_linear_interp_16bit_modes_top_macros.svh"

module lut_linear_interp_16bit_modes_top #(
   parameter int MAX_POINTS = lli_pkg::MAX_POINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // point_index, point_x, point_y, query_x, lut_mode, zero pad
   input  logic [lli_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // command
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // result_y
   output logic [lli_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lli_pkg::COUNT_W-1:0]      csr_data
);
   import lli_pkg::*;

   lli_cmd_type    cmd;
   lli_status_type status;
   logic           lookup_beat;
   logic           write_beat;

   assign csr_ready = 1'b1;

   assign lookup_beat = req_tvalid && req_tready && (req_tuser == CMD_LOOKUP);
   assign write_beat  = req_tvalid && req_tready && (req_tuser == CMD_WRITE);

   lli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lli_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

   `LLI_ASSERT_NEXT(a_lookup_holds_off, clock, reset, lookup_beat, !req_tready)
   `LLI_ASSERT_NEXT(a_write_stays_ready, clock, reset, write_beat, req_tready)
   `LLI_ASSERT_IMPL(a_rsp_from_busy, clock, reset, $rose(rsp_tvalid), $past(!req_tready))

endmodule

// ===== tb/sv/tb_lut_linear_interp_16bit_modes_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise linear interpolation lookup table top level
module tb_lut_linear_interp_16bit_modes_top;
   import lli_pkg::*;

   localparam int NUM_POINTS       = MAX_POINTS_DEF;
   localparam int RANDOM_BEATS     = 1300;
   localparam int SETTLE_CYCLES    = 120;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int CYCLE_LIMIT      = 1000000;
   localparam int NUM_DIRECTED     = 24;

   typedef struct {
      int                csr_count;
      logic              cmd;
      int                idx;
      int                px;
      int                py;
      int                qx;
      logic [MODE_W-1:0] mode;
      bit                typed;
      int                typed_y;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [COUNT_W-1:0]     csr_data;

   longint      pt_x [NUM_POINTS];
   longint      pt_y [NUM_POINTS];
   int          pt_count;
   logic [15:0] result_q [$];
   int          fail_count;
   int          cycle_count;
   int          burst_left;
   int          beats_sent;
   bit          steady_feed;
   bit          long_hold_req;

   // csr_count -1 keeps point_count as it is
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{-1, CMD_LOOKUP,  0,     0,      0,      0, MODE_EXTRAP,   1'b1,      0},
      '{ 1, CMD_LOOKUP, 15,    -1,     -1, -32768, MODE_CALIB,    1'b1,      0},
      '{-1, CMD_WRITE,   0, -1000,    500,      0, MODE_EXTRAP,   1'b0,      0},
      '{-1, CMD_WRITE,   1,     0,   -500,      0, MODE_EXTRAP,   1'b0,      0},
      '{-1, CMD_WRITE,   2,  1000,   1500,      0, MODE_EXTRAP,   1'b0,      0},
      '{-1, CMD_WRITE,   3,  1000,   3000,      0, MODE_EXTRAP,   1'b0,      0},
      '{ 4, CMD_LOOKUP,  0,     0,      0,  -1000, MODE_EXTRAP,   1'b1,    500},
      '{-1, CMD_LOOKUP,  0,     0,      0, -32768, MODE_LIMIT,    1'b1,    500},
      '{-1, CMD_LOOKUP,  0,     0,      0, -32768, MODE_EXTRAP,   1'b0,      0},
      '{-1, CMD_LOOKUP,  0,     0,      0, -32768, MODE_POSITIVE, 1'b0,      0},
      '{-1, CMD_LOOKUP,  0,     0,      0,    500, MODE_EXTRAP,   1'b0,      0},
      '{-1, CMD_LOOKUP,  0,     0,      0,      0, MODE_EXTRAP,   1'b1,   -500},
      '{-1, CMD_LOOKUP,  0,     0,      0,      0, MODE_POSITIVE, 1'b1,      0},
      '{-1, CMD_LOOKUP,  0,     0,      0,      0, MODE_CALIB,    1'b1,      0},
      '{-1, CMD_LOOKUP,  0,     0,      0,  32767, MODE_EXTRAP,   1'b0,      0},
      '{-1, CMD_LOOKUP,  0,     0,      0,  32767, MODE_CALIB,    1'b1,  32767},
      '{-1, CMD_LOOKUP,  0,     0,      0,  32767, MODE_LIMIT,    1'b0,      0},
      '{-1, CMD_WRITE,   0,     0, -32768,      0, MODE_EXTRAP,   1'b0,      0},
      '{-1, CMD_WRITE,   1,     1,  32767,      0, MODE_EXTRAP,   1'b0,      0},
      '{ 2, CMD_LOOKUP,  0,     0,      0, -32768, MODE_EXTRAP,   1'b1, -32768},
      '{-1, CMD_LOOKUP,  0,     0,      0, -32768, MODE_POSITIVE, 1'b1,      0},
      '{-1, CMD_LOOKUP,  0,     0,      0,  32767, MODE_EXTRAP,   1'b1,  32767},
      '{-1, CMD_LOOKUP,  0,     0,      0,  32767, MODE_CALIB,    1'b1,      0},
      '{-1, CMD_LOOKUP,  0,     0,      0,  32767, MODE_LIMIT,    1'b0,      0}
   };

   int first_counts [8] = '{16, 31, 2, 17, 0, 1, 3, 8};

   lut_linear_interp_16bit_modes_top #(
      .MAX_POINTS(NUM_POINTS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] interp_y(input longint q, input logic [MODE_W-1:0] mode);
      int     n;
      int     k;
      int     i;
      longint dx;
      longint y2;
      longint xr;
      longint num;
      longint den;
      longint r;
      bit     fixed;
      n = (pt_count > NUM_POINTS) ? NUM_POINTS : pt_count;
      k = 0;
      dx = 0;
      y2 = 0;
      r = 0;
      fixed = 1'b0;
      if (n < 2) begin
         fixed = 1'b1;
      end else if (q > pt_x[n-1]) begin
         k = n - 2;
         dx = pt_x[n-1] - q;
         y2 = pt_y[n-1];
         if (mode == MODE_CALIB) begin
            r = q - (pt_x[k] - pt_y[k]);
            fixed = 1'b1;
         end
      end else begin
         for (i = 1; i < n; i++) begin
            if (q <= pt_x[i]) begin
               k = i - 1;
               xr = pt_x[i];
               y2 = pt_y[i];
               if (q < pt_x[0]) begin
                  xr = pt_x[0];
                  y2 = pt_y[0];
               end
               dx = xr - q;
               break;
            end
         end
         if (mode == MODE_LIMIT && q < pt_x[0]) begin
            r = pt_y[0];
            fixed = 1'b1;
         end
      end
      if (!fixed) begin
         num = (pt_y[k+1] - pt_y[k]) * dx;
         den = pt_x[k+1] - pt_x[k];
         r = y2;
         if (den != 0) begin
            r = y2 - num / den;
         end
      end
      if (r > 32767) begin
         r = 32767;
      end else if (r < -32768) begin
         r = -32768;
      end
      if ((mode == MODE_POSITIVE || mode == MODE_CALIB) && r < 0) begin
         r = 0;
      end
      return r[15:0];
   endfunction

   function automatic int pick_query();
      int     n;
      int     j;
      longint v;
      n = (pt_count > NUM_POINTS) ? NUM_POINTS : pt_count;
      if (n < 2) begin
         n = 2;
      end
      j = $urandom_range(0, n - 2);
      case ($urandom_range(0, 6))
         0: v = longint'($signed(16'($urandom)));
         1: v = pt_x[$urandom_range(0, n - 1)];
         2: v = pt_x[j] + int'($urandom_range(0, 6)) - 3;
         3: v = pt_x[j] + (pt_x[j+1] - pt_x[j]) * int'($urandom_range(0, 100)) / 100;
         4: v = $urandom_range(0, 1) ? 32767 : -32768;
         5: v = pt_x[n-1] + int'($urandom_range(1, 300));
         default: v = pt_x[0] - int'($urandom_range(1, 300));
      endcase
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      return int'(v);
   endfunction

   task automatic send_beat(input logic cmd, input int idx, input int px, input int py,
                            input int qx, input logic [MODE_W-1:0] mode,
                            input bit typed, input int typed_y);
      int gap;
      if (!steady_feed) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 12);
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, mode, qx[15:0], py[15:0], px[15:0], idx[INDEX_W-1:0]};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_WRITE) begin
         pt_x[idx] = longint'($signed(px[15:0]));
         pt_y[idx] = longint'($signed(py[15:0]));
      end else if (typed) begin
         result_q.push_back(typed_y[15:0]);
      end else begin
         result_q.push_back(interp_y(longint'($signed(qx[15:0])), mode));
      end
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (result_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_point_count(input int value);
      csr_valid <= 1'b1;
      csr_data  <= value[COUNT_W-1:0];
      do @(posedge clock); while (!csr_ready);
      pt_count = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_points();
      int     style;
      int     i;
      int     slot;
      longint xs [NUM_POINTS];
      longint xv;
      style = $urandom_range(0, 3);
      xv = (style == 1) ? -int'($urandom_range(0, 200)) : -32768 + int'($urandom_range(0, 20000));
      for (i = 0; i < NUM_POINTS; i++) begin
         if (style == 2) begin
            xs[i] = longint'($signed(16'($urandom)));
         end else begin
            xs[i] = xv;
            if (style == 1) begin
               xv = xv + int'($urandom_range(1, 3));
            end else if ($urandom_range(0, 7) != 0) begin
               xv = xv + int'($urandom_range(1, 4500));
            end
            if (xv > 32767) begin
               xv = 32767;
            end
         end
      end
      for (i = 0; i < NUM_POINTS; i++) begin
         slot = (style == 3) ? NUM_POINTS - 1 - i : i;
         send_beat(CMD_WRITE, slot, int'(xs[slot]), int'($signed(16'($urandom))),
                   int'($urandom), MODE_W'($urandom_range(0, 3)), 1'b0, 0);
      end
   endtask

   // receiver: stall pattern of its own, plus a long hold on request
   initial begin
      int pat_left;
      int ready_pct;
      pat_left = 0;
      ready_pct = 100;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else begin
            if (pat_left == 0) begin
               pat_left = $urandom_range(50, 400);
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 75;
                  2: ready_pct = 40;
                  default: ready_pct = 10;
               endcase
            end
            pat_left--;
            rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_q.size() == 0) begin
            $error("result_y: beat with no expected value, actual %0d", $signed(rsp_tdata));
            fail_count++;
         end else begin
            want = result_q.pop_front();
            if (rsp_tdata !== want) begin
               $error("result_y: expected %0d, actual %0d", $signed(want), $signed(rsp_tdata));
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int r;
      int p;
      int n;
      int count_sel;
      fail_count = 0;
      cycle_count = 0;
      burst_left = 0;
      beats_sent = 0;
      steady_feed = 1'b0;
      long_hold_req = 1'b0;
      pt_count = 0;
      for (r = 0; r < NUM_POINTS; r++) begin
         pt_x[r] = 0;
         pt_y[r] = 0;
      end
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < NUM_DIRECTED; r++) begin
         if (directed_rows[r].csr_count >= 0) begin
            drain_and_settle();
            write_point_count(directed_rows[r].csr_count);
         end
         send_beat(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].px,
                   directed_rows[r].py, directed_rows[r].qx, directed_rows[r].mode,
                   directed_rows[r].typed, directed_rows[r].typed_y);
      end

      beats_sent = 0;
      p = 0;
      while (beats_sent < RANDOM_BEATS) begin
         drain_and_settle();
         if (p < 8) begin
            count_sel = first_counts[p];
         end else if ($urandom_range(0, 9) < 7) begin
            count_sel = $urandom_range(2, 16);
         end else begin
            count_sel = $urandom_range(0, 31);
         end
         write_point_count(count_sel);
         if (p == 0 || $urandom_range(0, 2) == 0) begin
            load_points();
         end
         steady_feed = ($urandom_range(0, 3) == 0);
         n = $urandom_range(20, 70);
         if (p % 10 == 3) begin
            steady_feed = 1'b1;
            long_hold_req = 1'b1;
            n = 40;
         end
         repeat (n) begin
            if ($urandom_range(0, 7) == 0) begin
               send_beat(CMD_WRITE, $urandom_range(0, NUM_POINTS - 1),
                         int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                         int'($urandom), MODE_W'($urandom_range(0, 3)), 1'b0, 0);
            end else begin
               send_beat(CMD_LOOKUP, $urandom_range(0, NUM_POINTS - 1), int'($urandom),
                         int'($urandom), pick_query(), MODE_W'($urandom_range(0, 3)),
                         1'b0, 0);
            end
         end
         p++;
      end

      drain_and_settle();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lli_pkg.sv
hdl/lli_div.sv
hdl/lli_datapath.sv
hdl/lli_ctrl.sv
hdl/lut_linear_interp_16bit_modes_top.sv
tb/sv/tb_lut_linear_interp_16bit_modes_top.sv
